### sv/sir_pkg.sv
// ----------------------------------------------------------------------------
// sir_pkg
// Types and constants shared by the small island remover modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sir_pkg;

    localparam int PIX_W    = 32;
    localparam int COLOUR_W = 24;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // configuration register indexes
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ISLAND_LIMIT = 2'd2;

    // item actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // neighbour directions, visited in this order
    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_PROC
    } sir_state_t;

    typedef enum logic [4:0] {
        F_IDLE,
        F_SEED,
        F_SEEDW,
        F_POP,
        F_POPW,
        F_NB,
        F_NBW,
        F_MRD,
        F_MRDW,
        F_TNB,
        F_TNBW,
        F_TS,
        F_TSW,
        F_BRD,
        F_BRW,
        F_WR,
        F_WRW
    } fill_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fill_stat_t;

    // ordering key: blue first, then green, then red
    function automatic logic [COLOUR_W-1:0] order_key(input logic [COLOUR_W-1:0] c);
        return {c[7:0], c[15:8], c[23:16]};
    endfunction

endpackage

`default_nettype wire

### sv/sir_ram.sv
// ----------------------------------------------------------------------------
// sir_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sir_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [AW-1:0]        raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/sir_fill.sv
// ----------------------------------------------------------------------------
// sir_fill
// Flood-fill engine: scans the frame, grows 4-connected regions through a
// stack memory, tallies neighbour colours of small regions and recolors them.
// ----------------------------------------------------------------------------
`default_nettype none

module sir_fill import sir_pkg::*; #(
    parameter int  MAX_WIDTH  = 128,
    parameter int  MAX_HEIGHT = 128,
    parameter int  MAX_ISLAND = 64,
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW         = (CELLS > 1) ? $clog2(CELLS) : 1,
    localparam int NW         = $clog2(CELLS + 1),
    localparam int WW         = $clog2(MAX_WIDTH + 1),
    localparam int HW         = $clog2(MAX_HEIGHT + 1),
    localparam int SW         = $clog2(MAX_ISLAND + 2),
    localparam int FW         = PIX_W + 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [WW-1:0]     used_w,
    input  wire logic [HW-1:0]     used_h,
    input  wire logic [NW-1:0]     total,
    input  wire logic [SW-1:0]     limit,
    output logic      [AW-1:0]     frame_raddr,
    input  wire logic [FW-1:0]     frame_rdata,
    output logic                   frame_we,
    output logic      [AW-1:0]     frame_waddr,
    output logic      [FW-1:0]     frame_wdata,
    output fill_stat_t             stat
);

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MIW   = $clog2(MAX_ISLAND + 1);
    localparam int TD    = 4 * MAX_ISLAND;
    localparam int TIW   = $clog2(TD);
    localparam int TCW   = $clog2(TD + 1);
    localparam int SKW   = AW + XW + YW;
    localparam int TEW   = TCW + COLOUR_W;

    fill_state_t state_reg, state_next;

    logic [NW-1:0]       idx_reg;
    logic [XW-1:0]       sx_reg;
    logic [YW-1:0]       sy_reg;
    logic [NW-1:0]       sp_reg;
    logic [SW-1:0]       size_reg;
    logic [SW-1:0]       mi_reg;
    logic [1:0]          d_reg;
    logic [PIX_W-1:0]    target_reg;
    logic [AW-1:0]       cur_p_reg;
    logic [XW-1:0]       cur_x_reg;
    logic [YW-1:0]       cur_y_reg;
    logic [COLOUR_W-1:0] colour_reg;
    logic [TCW-1:0]      ti_reg;
    logic [TCW-1:0]      used_reg;
    logic [TCW-1:0]      best_cnt_reg;
    logic [COLOUR_W-1:0] best_col_reg;

    // stack, member list and colour tally memories
    logic              stk_we;
    logic [AW-1:0]     stk_waddr, stk_raddr;
    logic [SKW-1:0]    stk_wdata, stk_rdata;
    logic              mem_we;
    logic [MIW-1:0]    mem_waddr, mem_raddr;
    logic [SKW-1:0]    mem_wdata, mem_rdata;
    logic              tly_we;
    logic [TIW-1:0]    tly_waddr, tly_raddr;
    logic [TEW-1:0]    tly_wdata, tly_rdata;

    sir_ram #(.WIDTH(SKW), .DEPTH(CELLS)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    sir_ram #(.WIDTH(SKW), .DEPTH(MAX_ISLAND + 1)) u_members (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sir_ram #(.WIDTH(TEW), .DEPTH(TD)) u_tally (
        .clk   (clk),
        .we    (tly_we),
        .waddr (tly_waddr),
        .wdata (tly_wdata),
        .raddr (tly_raddr),
        .rdata (tly_rdata)
    );

    // shared conditions
    logic                nb_ok;
    logic [AW-1:0]       nb_p;
    logic [XW-1:0]       nb_x;
    logic [YW-1:0]       nb_y;
    logic                last_d;
    logic                seed_done;
    logic                sp_empty;
    logic                in_limit;
    logic                fr_vis;
    logic [PIX_W-1:0]    fr_pix;
    logic                nb_match;
    logic                mem_done;
    logic                ts_end;
    logic [TCW-1:0]      t_cnt;
    logic [COLOUR_W-1:0] t_col;
    logic                t_hit;
    logic                better;
    logic                sx_wrap;

    always_comb
    begin
        nb_ok = 1'b0;
        nb_p  = cur_p_reg;
        nb_x  = cur_x_reg;
        nb_y  = cur_y_reg;
        unique case (d_reg)
            DIR_DOWN:
            begin
                nb_ok = (HW'(cur_y_reg) + HW'(1)) < used_h;
                nb_p  = cur_p_reg + AW'(used_w);
                nb_y  = cur_y_reg + YW'(1);
            end
            DIR_RIGHT:
            begin
                nb_ok = (WW'(cur_x_reg) + WW'(1)) < used_w;
                nb_p  = cur_p_reg + AW'(1);
                nb_x  = cur_x_reg + XW'(1);
            end
            DIR_UP:
            begin
                nb_ok = cur_y_reg != '0;
                nb_p  = cur_p_reg - AW'(used_w);
                nb_y  = cur_y_reg - YW'(1);
            end
            DIR_LEFT:
            begin
                nb_ok = cur_x_reg != '0;
                nb_p  = cur_p_reg - AW'(1);
                nb_x  = cur_x_reg - XW'(1);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign last_d    = d_reg == DIR_LEFT;
    assign seed_done = (limit == '0) || (idx_reg >= total);
    assign sp_empty  = sp_reg == '0;
    assign in_limit  = size_reg <= limit;
    assign fr_vis    = frame_rdata[FW-1];
    assign fr_pix    = frame_rdata[PIX_W-1:0];
    assign nb_match  = !fr_vis && (fr_pix == target_reg);
    assign mem_done  = mi_reg == size_reg;
    assign ts_end    = ti_reg == used_reg;
    assign t_cnt     = tly_rdata[TEW-1 -: TCW];
    assign t_col     = tly_rdata[COLOUR_W-1:0];
    assign t_hit     = t_col == colour_reg;
    assign better    = (ti_reg == '0) || (t_cnt > best_cnt_reg) ||
                       ((t_cnt == best_cnt_reg) &&
                        (order_key(t_col) < order_key(best_col_reg)));
    assign sx_wrap   = (WW'(sx_reg) + WW'(1)) == used_w;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (start) state_next = F_SEED;
            F_SEED:  state_next = seed_done ? F_IDLE : F_SEEDW;
            F_SEEDW: state_next = fr_vis ? F_SEED : F_POP;
            F_POP:
            begin
                if (!sp_empty)
                    state_next = F_POPW;
                else
                    state_next = in_limit ? F_MRD : F_SEED;
            end
            F_POPW:  state_next = F_NB;
            F_NB:
            begin
                if (nb_ok)
                    state_next = F_NBW;
                else
                    state_next = last_d ? F_POP : F_NB;
            end
            F_NBW:   state_next = last_d ? F_POP : F_NB;
            F_MRD:
            begin
                if (!mem_done)
                    state_next = F_MRDW;
                else
                    state_next = (used_reg == '0) ? F_SEED : F_BRD;
            end
            F_MRDW:  state_next = F_TNB;
            F_TNB:
            begin
                if (nb_ok)
                    state_next = F_TNBW;
                else
                    state_next = last_d ? F_MRD : F_TNB;
            end
            F_TNBW:  state_next = F_TS;
            F_TS:
            begin
                if (ts_end)
                    state_next = last_d ? F_MRD : F_TNB;
                else
                    state_next = F_TSW;
            end
            F_TSW:
            begin
                if (t_hit)
                    state_next = last_d ? F_MRD : F_TNB;
                else
                    state_next = F_TS;
            end
            F_BRD:   state_next = ts_end ? F_WR : F_BRW;
            F_BRW:   state_next = F_BRD;
            F_WR:    state_next = mem_done ? F_SEED : F_WRW;
            F_WRW:   state_next = F_WR;
            default: state_next = F_IDLE;
        endcase
    end

    // memory controls and status
    always_comb
    begin
        frame_raddr = nb_p;
        frame_we    = 1'b0;
        frame_waddr = nb_p;
        frame_wdata = {1'b1, fr_pix};
        stk_we      = 1'b0;
        stk_waddr   = sp_reg[AW-1:0];
        stk_wdata   = {nb_p, nb_x, nb_y};
        stk_raddr   = sp_reg[AW-1:0] - AW'(1);
        mem_we      = 1'b0;
        mem_waddr   = size_reg[MIW-1:0];
        mem_wdata   = stk_rdata;
        mem_raddr   = mi_reg[MIW-1:0];
        tly_we      = 1'b0;
        tly_waddr   = used_reg[TIW-1:0];
        tly_wdata   = {TCW'(1), colour_reg};
        tly_raddr   = ti_reg[TIW-1:0];
        unique case (state_reg)
            F_SEED:
            begin
                frame_raddr = idx_reg[AW-1:0];
            end
            F_SEEDW:
            begin
                frame_waddr = idx_reg[AW-1:0];
                frame_we    = !fr_vis;
                stk_we      = !fr_vis;
                stk_waddr   = '0;
                stk_wdata   = {idx_reg[AW-1:0], sx_reg, sy_reg};
            end
            F_POPW:
            begin
                mem_we = in_limit;
            end
            F_NBW:
            begin
                frame_we = nb_match;
                stk_we   = nb_match;
            end
            F_TS:
            begin
                tly_we = ts_end;
            end
            F_TSW:
            begin
                tly_we    = t_hit;
                tly_waddr = ti_reg[TIW-1:0];
                tly_wdata = {t_cnt + TCW'(1), colour_reg};
            end
            F_WRW:
            begin
                frame_we    = 1'b1;
                frame_waddr = mem_rdata[SKW-1 -: AW];
                frame_wdata = {1'b1, ALPHA_OPAQUE, best_col_reg};
            end
            default:
            begin
                frame_we = 1'b0;
            end
        endcase
        stat.busy = state_reg != F_IDLE;
        stat.done = (state_reg == F_SEED) && seed_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                idx_reg <= '0;
                sx_reg  <= '0;
                sy_reg  <= '0;
            end
            F_SEEDW:
            begin
                // advance the scan; the seed itself now lives on the stack
                idx_reg <= idx_reg + NW'(1);
                if (sx_wrap)
                begin
                    sx_reg <= '0;
                    sy_reg <= sy_reg + YW'(1);
                end
                else
                begin
                    sx_reg <= sx_reg + XW'(1);
                end
                target_reg <= fr_pix;
                sp_reg     <= NW'(1);
                size_reg   <= '0;
            end
            F_POP:
            begin
                if (!sp_empty)
                    sp_reg <= sp_reg - NW'(1);
                mi_reg   <= '0;
                used_reg <= '0;
            end
            F_POPW:
            begin
                cur_p_reg <= stk_rdata[SKW-1 -: AW];
                cur_x_reg <= stk_rdata[XW+YW-1 -: XW];
                cur_y_reg <= stk_rdata[YW-1:0];
                if (in_limit)
                    size_reg <= size_reg + SW'(1);
                d_reg <= DIR_DOWN;
            end
            F_NB:
            begin
                if (!nb_ok)
                    d_reg <= d_reg + 2'd1;
            end
            F_NBW:
            begin
                if (nb_match)
                    sp_reg <= sp_reg + NW'(1);
                d_reg <= d_reg + 2'd1;
            end
            F_MRD:
            begin
                ti_reg <= '0;
            end
            F_MRDW:
            begin
                cur_p_reg <= mem_rdata[SKW-1 -: AW];
                cur_x_reg <= mem_rdata[XW+YW-1 -: XW];
                cur_y_reg <= mem_rdata[YW-1:0];
                d_reg     <= DIR_DOWN;
                mi_reg    <= mi_reg + SW'(1);
            end
            F_TNB:
            begin
                if (!nb_ok)
                    d_reg <= d_reg + 2'd1;
            end
            F_TNBW:
            begin
                colour_reg <= frame_rdata[COLOUR_W-1:0];
                ti_reg     <= '0;
            end
            F_TS:
            begin
                if (ts_end)
                begin
                    used_reg <= used_reg + TCW'(1);
                    d_reg    <= d_reg + 2'd1;
                end
            end
            F_TSW:
            begin
                if (t_hit)
                    d_reg <= d_reg + 2'd1;
                else
                    ti_reg <= ti_reg + TCW'(1);
            end
            F_BRD:
            begin
                mi_reg <= '0;
            end
            F_BRW:
            begin
                if (better)
                begin
                    best_cnt_reg <= t_cnt;
                    best_col_reg <= t_col;
                end
                ti_reg <= ti_reg + TCW'(1);
            end
            F_WRW:
            begin
                mi_reg <= mi_reg + SW'(1);
            end
            default:
            begin
                d_reg <= d_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/small_island_remover.sv
// ----------------------------------------------------------------------------
// small_island_remover
// Loads a BGRA frame, removes small 4-connected islands, streams it back.
// ----------------------------------------------------------------------------
// A load item is stored straight away; a read item passes the frame memory
// read, then the result register, and the next item waits for it. The load
// that completes the frame starts the fill pass, during which items stall:
// the scan reads each pixel; the fill pops each region member from the stack
// and checks each direction, reading each in-frame neighbour; for every
// island that is recolored, each member is fetched, each direction checked
// and each in-frame neighbour read, the colour tally is searched linearly
// for each neighbour (a new colour is appended, up to four entries per
// member), one pass over the tally picks the winner and every member is
// written back. The single frame memory port pair paces these steps.
// Visited marks live in the frame words and are cleared as pixels load, so
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module small_island_remover import sir_pkg::*; #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128,
    parameter int MAX_ISLAND = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        action,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  alpha,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [7:0]       out_blue,
    output logic [7:0]       out_green,
    output logic [7:0]       out_red,
    output logic [7:0]       out_alpha,
    output logic             ready_res,
    output logic             last_pixel
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int NW    = $clog2(CELLS + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int SW    = $clog2(MAX_ISLAND + 2);
    localparam int FW    = PIX_W + 1;

    sir_state_t state_reg, state_next;

    logic [7:0]    width_reg;
    logic [7:0]    height_reg;
    logic [6:0]    limit_reg;
    logic [NW-1:0] load_count_reg;
    logic [NW-1:0] read_count_reg;
    logic          frame_ready_reg;
    logic          result_valid_reg;
    logic          hit_reg;
    logic          last_reg;
    logic [7:0]    out_blue_reg, out_green_reg, out_red_reg, out_alpha_reg;
    logic          ready_res_reg, last_pixel_reg;

    logic [WW-1:0] used_w;
    logic [HW-1:0] used_h;
    logic [NW-1:0] total;
    logic [SW-1:0] limit;

    logic item_acc, load_acc, read_acc;
    logic load_store, load_fin, read_last;

    logic          eng_start;
    fill_stat_t    stat;
    logic [AW-1:0] eng_raddr, eng_waddr;
    logic          eng_we;
    logic [FW-1:0] eng_wdata;

    logic          fr_we;
    logic [AW-1:0] fr_waddr, fr_raddr;
    logic [FW-1:0] fr_wdata, fr_rdata;

    // clamp the configured geometry and island limit
    always_comb
    begin
        priority if (width_reg == '0)
            used_w = WW'(1);
        else if (16'(width_reg) > 16'(MAX_WIDTH))
            used_w = WW'(MAX_WIDTH);
        else
            used_w = WW'(width_reg);
        priority if (height_reg == '0)
            used_h = HW'(1);
        else if (16'(height_reg) > 16'(MAX_HEIGHT))
            used_h = HW'(MAX_HEIGHT);
        else
            used_h = HW'(height_reg);
        if (16'(limit_reg) > 16'(MAX_ISLAND))
            limit = SW'(MAX_ISLAND);
        else
            limit = SW'(limit_reg);
    end

    assign total = NW'(NW'(used_w) * NW'(used_h));

    assign cfg_ready  = 1'b1;
    assign item_stall = (state_reg != S_IDLE) ||
                        (result_valid_reg && result_stall && action == ACT_READ);
    assign item_acc   = item_valid && !item_stall;
    assign load_acc   = item_acc && action == ACT_LOAD;
    assign read_acc   = item_acc && action == ACT_READ;
    assign load_store = load_count_reg < total;
    assign load_fin   = load_store ? ((load_count_reg + NW'(1)) >= total) : 1'b1;
    assign read_last  = (read_count_reg + NW'(1)) >= total;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (load_acc && !frame_ready_reg && load_fin)
                    state_next = S_PROC;
                else if (read_acc)
                    state_next = S_READ;
            end
            S_READ:  state_next = S_IDLE;
            S_PROC:  state_next = stat.done ? S_IDLE : S_PROC;
            default: state_next = S_IDLE;
        endcase
    end

    // frame memory port selection
    always_comb
    begin
        eng_start = (state_reg == S_IDLE) && (state_next == S_PROC);
        if (state_reg == S_PROC)
        begin
            fr_we    = eng_we;
            fr_waddr = eng_waddr;
            fr_wdata = eng_wdata;
            fr_raddr = eng_raddr;
        end
        else
        begin
            fr_we    = load_acc && !frame_ready_reg && load_store;
            fr_waddr = load_count_reg[AW-1:0];
            fr_wdata = {1'b0, alpha, red, green, blue};
            fr_raddr = read_count_reg[AW-1:0];
        end
    end

    sir_ram #(.WIDTH(FW), .DEPTH(CELLS)) u_frame (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    sir_fill #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_ISLAND (MAX_ISLAND)
    ) u_fill (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (eng_start),
        .used_w      (used_w),
        .used_h      (used_h),
        .total       (total),
        .limit       (limit),
        .frame_raddr (eng_raddr),
        .frame_rdata (fr_rdata),
        .frame_we    (eng_we),
        .frame_waddr (eng_waddr),
        .frame_wdata (eng_wdata),
        .stat        (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            width_reg        <= 8'd128;
            height_reg       <= 8'd128;
            limit_reg        <= 7'd0;
            load_count_reg   <= '0;
            read_count_reg   <= '0;
            frame_ready_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    REG_ISLAND_LIMIT: limit_reg  <= cfg_data[6:0];
                    default:          limit_reg  <= limit_reg;
                endcase
            end
            if (load_acc && !frame_ready_reg && load_store)
                load_count_reg <= load_count_reg + NW'(1);
            if (stat.done && state_reg == S_PROC)
            begin
                frame_ready_reg <= 1'b1;
                read_count_reg  <= '0;
            end
            if (read_acc && frame_ready_reg)
            begin
                if (read_last)
                begin
                    // end of readback: open for the next frame
                    frame_ready_reg <= 1'b0;
                    load_count_reg  <= '0;
                    read_count_reg  <= '0;
                end
                else
                begin
                    read_count_reg <= read_count_reg + NW'(1);
                end
            end
            if (state_reg == S_READ)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (read_acc)
        begin
            hit_reg  <= frame_ready_reg;
            last_reg <= read_last;
        end
        if (state_reg == S_READ)
        begin
            out_blue_reg   <= hit_reg ? fr_rdata[7:0]   : 8'd0;
            out_green_reg  <= hit_reg ? fr_rdata[15:8]  : 8'd0;
            out_red_reg    <= hit_reg ? fr_rdata[23:16] : 8'd0;
            out_alpha_reg  <= hit_reg ? fr_rdata[31:24] : 8'd0;
            ready_res_reg  <= hit_reg;
            last_pixel_reg <= hit_reg && last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_blue     = out_blue_reg;
    assign out_green    = out_green_reg;
    assign out_red      = out_red_reg;
    assign out_alpha    = out_alpha_reg;
    assign ready_res    = ready_res_reg;
    assign last_pixel   = last_pixel_reg;

    a_busy_in_proc: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> state_reg == S_PROC)
        else $error("fill engine busy outside processing");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == S_READ)
        else $error("result appeared without a read");

    a_last_is_ready: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && last_pixel_reg |-> ready_res_reg)
        else $error("last pixel flagged on an empty read");

    a_ready_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROC && stat.done |=> frame_ready_reg)
        else $error("frame not ready after processing");

endmodule

`default_nettype wire

### sim/tb_small_island_remover.sv
// ----------------------------------------------------------------------------
// tb_small_island_remover
// Self-checking bench for the small island remover. Small frames with
// few-colour content are loaded, processed and read back under random
// stalls on both sides. Each read result is held to a directed value or a behavioral
// flood-fill model kept in step with every accepted item and register write.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_small_island_remover import sir_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELL_COUNT  = 128 * 128;
    localparam int ISLAND_MAX  = 64;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int IDLE_WAIT   = 50;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        logic [7:0] a;
        logic       rdy;
        logic       last;
    } pixel_out_t;

    typedef struct {
        bit         is_cfg;
        logic [1:0] index;
        logic [7:0] data;
        logic       act;
        logic [31:0] pix;     // {a, r, g, b}
        bit         has_exp;
        pixel_out_t exp_px;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        item_valid;
    logic        item_stall;
    logic        action;
    logic [7:0]  blue, green, red, alpha;
    logic        result_valid;
    logic        result_stall;
    logic [7:0]  out_blue, out_green, out_red, out_alpha;
    logic        ready_res;
    logic        last_pixel;

    small_island_remover dut (.*);

    // behavioral image of the block
    logic [31:0] img_store [CELL_COUNT];
    bit          seen      [CELL_COUNT];
    int          fill_stk  [CELL_COUNT];
    int          members   [ISLAND_MAX + 1];
    logic [23:0] tally_col [4 * ISLAND_MAX];
    int          tally_cnt [4 * ISLAND_MAX];
    int          tally_used;
    int          loads_done;
    int          reads_done;
    bit          img_ready;
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    logic [6:0]  limit_reg;

    pixel_out_t  expected_pixels[$];
    int          mismatches;
    int          pixels_checked;
    int          items_sent;
    int          frames_done;
    int          cycles;
    bit          calm;

    const int step_x[4] = '{0, 1, 0, -1};
    const int step_y[4] = '{1, 0, -1, 0};

    function automatic int cols();
        return (width_reg == 0) ? 1 : (width_reg > 128) ? 128 : int'(width_reg);
    endfunction

    function automatic int rows();
        return (height_reg == 0) ? 1 : (height_reg > 128) ? 128 : int'(height_reg);
    endfunction

    function automatic bit adjacent(int p, int d, int w, int h, output int q);
        int x, y;
        x = p % w + step_x[d];
        y = p / w + step_y[d];
        q = y * w + x;
        return !(x < 0 || y < 0 || x >= w || y >= h);
    endfunction

    function automatic logic [23:0] bgr_rank(logic [23:0] c);
        return {c[7:0], c[15:8], c[23:16]};
    endfunction

    function automatic void count_colour(logic [23:0] c);
        for (int i = 0; i < tally_used; i++)
            if (tally_col[i] == c)
            begin
                tally_cnt[i]++;
                return;
            end
        if (tally_used < 4 * ISLAND_MAX)
        begin
            tally_col[tally_used] = c;
            tally_cnt[tally_used] = 1;
            tally_used++;
        end
    endfunction

    function automatic void repaint_island(int size, int w, int h);
        int q, best;
        best = 0;
        tally_used = 0;
        for (int i = 0; i < size; i++)
            for (int d = 0; d < 4; d++)
                if (adjacent(members[i], d, w, h, q))
                    count_colour(img_store[q][23:0]);
        if (tally_used == 0)
            return;
        for (int i = 1; i < tally_used; i++)
            if (tally_cnt[i] > tally_cnt[best] ||
                (tally_cnt[i] == tally_cnt[best] &&
                 bgr_rank(tally_col[i]) < bgr_rank(tally_col[best])))
                best = i;
        for (int i = 0; i < size; i++)
            img_store[members[i]] = {ALPHA_OPAQUE, tally_col[best]};
    endfunction

    function automatic void remove_islands();
        int w, h, lim, sp, size, p, q;
        logic [31:0] target;
        w = cols();
        h = rows();
        lim = (limit_reg > ISLAND_MAX) ? ISLAND_MAX : int'(limit_reg);
        if (lim == 0)
            return;
        for (int i = 0; i < w * h; i++)
            seen[i] = 0;
        for (int idx = 0; idx < w * h; idx++)
        begin
            if (seen[idx])
                continue;
            target = img_store[idx];
            sp = 0;
            size = 0;
            fill_stk[sp++] = idx;
            seen[idx] = 1;
            while (sp > 0)
            begin
                p = fill_stk[--sp];
                if (size <= lim)
                    members[size] = p;
                size++;
                for (int d = 0; d < 4; d++)
                    if (adjacent(p, d, w, h, q) && !seen[q] && img_store[q] == target)
                    begin
                        seen[q] = 1;
                        fill_stk[sp++] = q;
                    end
            end
            if (size <= lim)
                repaint_island(size, w, h);
        end
    endfunction

    // advance the image by one accepted item; returns 1 when a result is due
    function automatic bit apply_item(logic act, logic [31:0] pix, output pixel_out_t res);
        int total;
        logic [31:0] word;
        total = cols() * rows();
        res = '0;
        if (act == ACT_LOAD)
        begin
            if (img_ready)
                return 0;
            if (loads_done < total)
                img_store[loads_done++] = pix;
            if (loads_done >= total)
            begin
                remove_islands();
                img_ready = 1;
                reads_done = 0;
            end
            return 0;
        end
        if (!img_ready)
            return 1;
        word = img_store[(reads_done < CELL_COUNT) ? reads_done : CELL_COUNT - 1];
        res = {word[7:0], word[15:8], word[23:16], word[31:24], 1'b1, 1'b0};
        if (reads_done + 1 >= total)
        begin
            res.last = 1;
            img_ready = 0;
            loads_done = 0;
            reads_done = 0;
        end
        else
        begin
            reads_done++;
        end
        return 1;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d pixels pending", cycles,
                         expected_pixels.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // result side: random stall per item, one long hold-off to back up the block
    initial
    begin
        int gap;
        bit held;
        held = 0;
        result_stall = 1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && pixels_checked >= 40)
            begin
                held = 1;
                result_stall <= 1;
                repeat (400) @(negedge clk);
            end
            gap = calm ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                result_stall <= 1;
                repeat (gap) @(negedge clk);
            end
            result_stall <= 0;
            do @(posedge clk); while (!result_valid);
        end
    end

    always @(posedge clk)
    begin
        pixel_out_t got, want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = {out_blue, out_green, out_red, out_alpha, ready_res, last_pixel};
            pixels_checked++;
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pixel mismatch: bgra %h %h %h %h rdy %b last %b, ",
                                  "got %h %h %h %h rdy %b last %b"},
                                 want.b, want.g, want.r, want.a, want.rdy, want.last,
                                 got.b, got.g, got.r, got.a, got.rdy, got.last);
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] index, logic [7:0] data);
        item_valid <= 0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (IDLE_WAIT) @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            REG_FRAME_WIDTH:  width_reg  = data;
            REG_FRAME_HEIGHT: height_reg = data;
            REG_ISLAND_LIMIT: limit_reg  = data[6:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_item(logic act, logic [31:0] pix, bit has_exp, pixel_out_t typed);
        int gap;
        pixel_out_t res;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            item_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1;
        action <= act;
        {alpha, red, green, blue} <= pix;
        do @(posedge clk); while (item_stall);
        if (apply_item(act, pix, res))
            expected_pixels = {expected_pixels, (has_exp ? typed : res)};
        items_sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_pixel(logic [31:0] pal[3]);
        return ($urandom_range(0, 7) == 0) ? $urandom() : pal[$urandom_range(0, 2)];
    endfunction

    stim_row_t directed[$];

    task automatic add_cfg(logic [1:0] index, logic [7:0] data);
        stim_row_t row;
        row = '{1, index, data, ACT_LOAD, 32'h0, 0, '0};
        directed = {directed, row};
    endtask

    task automatic add_item(logic act, logic [31:0] pix, bit has_exp, pixel_out_t e);
        stim_row_t row;
        row = '{0, 2'd0, 8'd0, act, pix, has_exp, e};
        directed = {directed, row};
    endtask

    initial
    begin
        logic [31:0] pal[3];
        int n;
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = 0;
        item_valid = 0;
        action = ACT_LOAD;
        {blue, green, red, alpha} = '0;
        calm = 0;
        mismatches = 0;
        pixels_checked = 0;
        items_sent = 0;
        frames_done = 0;
        loads_done = 0;
        reads_done = 0;
        img_ready = 0;
        width_reg = 8'd128;
        height_reg = 8'd128;
        limit_reg = 7'd0;
        for (int i = 0; i < CELL_COUNT; i++)
            img_store[i] = '0;

        // read with nothing loaded gives all zero
        add_item(ACT_READ, 32'h0, 1, '0);
        // single pixel frame keeps its colour even with removal on
        add_cfg(REG_FRAME_WIDTH, 8'd1);
        add_cfg(REG_FRAME_HEIGHT, 8'd1);
        add_cfg(REG_ISLAND_LIMIT, 8'd64);
        add_item(ACT_LOAD, 32'h78563412, 0, '0);
        add_item(ACT_LOAD, 32'hFFFFFFFF, 0, '0);     // ignored, frame ready
        add_item(ACT_READ, 32'h0, 1, '{8'h12, 8'h34, 8'h56, 8'h78, 1'b1, 1'b1});
        // lone pixels recolored in place, later regions see the change
        add_cfg(REG_FRAME_WIDTH, 8'd3);
        add_cfg(REG_ISLAND_LIMIT, 8'd1);
        add_item(ACT_LOAD, 32'h281E140A, 0, '0);
        add_item(ACT_LOAD, 32'hFFFFFFFF, 0, '0);
        add_item(ACT_LOAD, 32'h281E140A, 0, '0);
        repeat (3) add_item(ACT_READ, 32'h0, 0, '0);
        // frame shrinks under a partial load: next load only starts the pass
        add_cfg(REG_FRAME_WIDTH, 8'd4);
        add_cfg(REG_ISLAND_LIMIT, 8'd0);
        add_item(ACT_LOAD, 32'h00000000, 0, '0);
        add_item(ACT_LOAD, 32'hFFFFFFFF, 0, '0);
        add_item(ACT_LOAD, 32'h5A5A5A5A, 0, '0);
        add_cfg(REG_FRAME_WIDTH, 8'd2);
        add_item(ACT_LOAD, 32'hA5A5A5A5, 0, '0);
        add_item(ACT_READ, 32'h0, 1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0});
        add_item(ACT_READ, 32'h0, 1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1});

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
                write_reg(directed[i].index, directed[i].data);
            else
                send_item(directed[i].act, directed[i].pix, directed[i].has_exp,
                          directed[i].exp_px);
        end

        while (items_sent < 1050)
        begin
            calm = ($urandom_range(0, 5) == 0);
            if (frames_done % 9 == 0)
            begin
                // extremes: widest row, tallest column, out-of-range register values
                write_reg(REG_FRAME_WIDTH, (frames_done % 18 == 0) ? 8'd255 : 8'd1);
                write_reg(REG_FRAME_HEIGHT, (frames_done % 18 == 0) ? 8'd1 : 8'd128);
                write_reg(REG_ISLAND_LIMIT, (frames_done % 27 == 0) ? 8'd127 : 8'd64);
            end
            else
            begin
                if ($urandom_range(0, 1))
                    write_reg(REG_FRAME_WIDTH, 8'($urandom_range(0, 8)));
                if ($urandom_range(0, 1))
                    write_reg(REG_FRAME_HEIGHT, 8'($urandom_range(0, 8)));
                if ($urandom_range(0, 1))
                    write_reg(REG_ISLAND_LIMIT,
                              $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 127))
                                                        : 8'($urandom_range(0, 6)));
            end
            foreach (pal[k])
                pal[k] = $urandom();
            n = cols() * rows();
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_item(ACT_READ, $urandom(), 0, '0);
                send_item(ACT_LOAD, pick_pixel(pal), 0, '0);
            end
            if ($urandom_range(0, 7) == 0)
                send_item(ACT_LOAD, $urandom(), 0, '0);
            for (int k = 0; k < n; k++)
                send_item(ACT_READ, $urandom(), 0, '0);
            frames_done++;
        end
        item_valid <= 0;
        calm = 0;

        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (IDLE_WAIT) @(negedge clk);

        $display("covered %0d items over %0d frames, %0d result pixels checked",
                 items_sent, frames_done, pixels_checked);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
